/* hw/rtl/point_segment_sq_distance_top_assert.svh */
// Assertion macros for the point-to-segment squared distance block.
`ifndef POINT_SEGMENT_SQ_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_SQ_DISTANCE_TOP_ASSERT_SVH

// Check that a condition implies a consequent in the same cycle.
`define PSD_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("psd check failed");

// Check that a condition implies a consequent in the next cycle.
`define PSD_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("psd check failed");

`endif

/* hw/rtl/psd_pkg.sv */
// Shared widths, types and region codes for the point-to-segment distance block.
package psd_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 2;
   localparam int HALF_WIDTH  = (DIST_WIDTH + 1) / 2;
   localparam int SQ_WIDTH    = 2 * DIST_WIDTH;
   localparam int DIV_STEPS   = DIST_WIDTH;
   localparam int PRE_STAGES  = 5;
   localparam int NUM_STAGES  = PRE_STAGES + DIV_STEPS + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [DIST_WIDTH-1:0]         dist_type;
   typedef logic [HALF_WIDTH-1:0]         half_type;
   typedef logic [2*HALF_WIDTH-1:0]       pp_type;
   typedef logic [SQ_WIDTH-1:0]           sq_type;

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

endpackage

/* hw/rtl/psd_if.sv */
// Request and response channel interfaces of the point-to-segment distance block.
interface psd_req_if;
   logic                 valid;
   logic                 ready;
   psd_pkg::coord_type   point_x;
   psd_pkg::coord_type   point_y;
   psd_pkg::coord_type   point_z;
   psd_pkg::coord_type   start_x;
   psd_pkg::coord_type   start_y;
   psd_pkg::coord_type   start_z;
   psd_pkg::coord_type   end_x;
   psd_pkg::coord_type   end_y;
   psd_pkg::coord_type   end_z;

   modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                   end_x, end_y, end_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                   end_x, end_y, end_z, output ready);
endinterface

interface psd_rsp_if;
   logic                 valid;
   logic                 ready;
   psd_pkg::dist_type    sq_distance;
   logic [1:0]           nearest_region;

   modport source (output valid, sq_distance, nearest_region, input ready);
   modport sink   (input valid, sq_distance, nearest_region, output ready);
endinterface

/* hw/rtl/point_segment_sq_distance_top.sv */
// Pipeline: 4 arithmetic stages, square, 34 divide steps, output; the restoring divider is unrolled
// one quotient bit a stage. Throughput: one request per cycle while the response is not stalled.
// A stalled response holds every stage in place; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
// Top level: squared distance from a 3-D point to a segment.
module point_segment_sq_distance_top (
   input  logic        clock,
   input  logic        reset,
   psd_req_if.sink     req_chan,
   psd_rsp_if.source   rsp_chan
);

   typedef struct packed {
      psd_pkg::dist_type   rem;
      psd_pkg::dist_type   dvd;
      psd_pkg::dist_type   quo;
      psd_pkg::dist_type   div;
      psd_pkg::dist_type   cand;
      psd_pkg::region_type region;
   } div_stage_type;

   // One restoring division step: shift in a dividend bit, subtract if it fits.
   function automatic div_stage_type div_step(input div_stage_type s);
      logic [psd_pkg::DIST_WIDTH:0] trial;
      logic [psd_pkg::DIST_WIDTH:0] diff;
      div_stage_type                r;
      r     = s;
      trial = {s.rem, s.dvd[psd_pkg::DIST_WIDTH-1]};
      diff  = trial - {1'b0, s.div};
      r.dvd = {s.dvd[psd_pkg::DIST_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, s.div}) begin
         r.rem = diff[psd_pkg::DIST_WIDTH-1:0];
         r.quo = {s.quo[psd_pkg::DIST_WIDTH-2:0], 1'b1};
      end else begin
         r.rem = trial[psd_pkg::DIST_WIDTH-1:0];
         r.quo = {s.quo[psd_pkg::DIST_WIDTH-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [psd_pkg::NUM_STAGES-1:0] vld_ff;
   logic                           advance;

   psd_pkg::coord_type c_in [3];
   psd_pkg::coord_type a_in [3];
   psd_pkg::coord_type b_in [3];

   psd_pkg::diff_type ab_ff [3];
   psd_pkg::diff_type ac_ff [3];
   psd_pkg::diff_type bc_ff [3];

   psd_pkg::prod_type pe_ff [3];
   psd_pkg::prod_type pf_ff [3];
   psd_pkg::prod_type pa_ff [3];
   psd_pkg::prod_type pb_ff [3];

   psd_pkg::sum_type e_ff;
   psd_pkg::sum_type f_ff;
   psd_pkg::sum_type daa_ff;
   psd_pkg::sum_type dbb_ff;

   psd_pkg::region_type region_in;
   psd_pkg::dist_type   e_mag;
   psd_pkg::half_type   e_hi;
   psd_pkg::half_type   e_lo;

   psd_pkg::pp_type     hh_ff;
   psd_pkg::pp_type     hl_ff;
   psd_pkg::pp_type     ll_ff;
   psd_pkg::dist_type   f4_ff;
   psd_pkg::dist_type   cand4_ff;
   psd_pkg::region_type region4_ff;

   psd_pkg::sq_type     sq_in;
   div_stage_type       div_ff [0:psd_pkg::DIV_STEPS];

   psd_pkg::dist_type   dist_ff;
   psd_pkg::region_type region_ff;

   // Advance the whole pipe unless the output holds an untaken response
   assign advance        = !vld_ff[psd_pkg::NUM_STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[psd_pkg::NUM_STAGES-2:0], req_chan.valid};
      end
   end

   // Gather coordinates into vectors
   always_comb begin
      c_in[0] = req_chan.point_x;
      c_in[1] = req_chan.point_y;
      c_in[2] = req_chan.point_z;
      a_in[0] = req_chan.start_x;
      a_in[1] = req_chan.start_y;
      a_in[2] = req_chan.start_z;
      b_in[0] = req_chan.end_x;
      b_in[1] = req_chan.end_y;
      b_in[2] = req_chan.end_z;
   end

   // Stages 1-3: differences, products, dot-product sums
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= psd_pkg::DIFF_WIDTH'(b_in[i]) - psd_pkg::DIFF_WIDTH'(a_in[i]);
            ac_ff[i] <= psd_pkg::DIFF_WIDTH'(c_in[i]) - psd_pkg::DIFF_WIDTH'(a_in[i]);
            bc_ff[i] <= psd_pkg::DIFF_WIDTH'(c_in[i]) - psd_pkg::DIFF_WIDTH'(b_in[i]);
            pe_ff[i] <= ac_ff[i] * ab_ff[i];
            pf_ff[i] <= ab_ff[i] * ab_ff[i];
            pa_ff[i] <= ac_ff[i] * ac_ff[i];
            pb_ff[i] <= bc_ff[i] * bc_ff[i];
         end
         e_ff   <= psd_pkg::SUM_WIDTH'(pe_ff[0]) + psd_pkg::SUM_WIDTH'(pe_ff[1])
                 + psd_pkg::SUM_WIDTH'(pe_ff[2]);
         f_ff   <= psd_pkg::SUM_WIDTH'(pf_ff[0]) + psd_pkg::SUM_WIDTH'(pf_ff[1])
                 + psd_pkg::SUM_WIDTH'(pf_ff[2]);
         daa_ff <= psd_pkg::SUM_WIDTH'(pa_ff[0]) + psd_pkg::SUM_WIDTH'(pa_ff[1])
                 + psd_pkg::SUM_WIDTH'(pa_ff[2]);
         dbb_ff <= psd_pkg::SUM_WIDTH'(pb_ff[0]) + psd_pkg::SUM_WIDTH'(pb_ff[1])
                 + psd_pkg::SUM_WIDTH'(pb_ff[2]);
      end
   end

   // Stage 4: classify the projection and split e for squaring
   always_comb begin
      priority if (e_ff[psd_pkg::SUM_WIDTH-1] || (e_ff == '0)) begin
         region_in = psd_pkg::REGION_START;
      end else if (e_ff >= f_ff) begin
         region_in = psd_pkg::REGION_END;
      end else begin
         region_in = psd_pkg::REGION_INTERIOR;
      end
      e_mag = e_ff[psd_pkg::DIST_WIDTH-1:0];
      e_lo  = e_mag[psd_pkg::HALF_WIDTH-1:0];
      e_hi  = psd_pkg::HALF_WIDTH'(e_mag >> psd_pkg::HALF_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hh_ff      <= e_hi * e_hi;
         hl_ff      <= e_hi * e_lo;
         ll_ff      <= e_lo * e_lo;
         f4_ff      <= f_ff[psd_pkg::DIST_WIDTH-1:0];
         cand4_ff   <= (region_in == psd_pkg::REGION_END) ? dbb_ff[psd_pkg::DIST_WIDTH-1:0]
                                                         : daa_ff[psd_pkg::DIST_WIDTH-1:0];
         region4_ff <= region_in;
      end
   end

   // Stage 5: combine partial products into e squared
   assign sq_in = (psd_pkg::SQ_WIDTH'(hh_ff) << (2 * psd_pkg::HALF_WIDTH))
                + (psd_pkg::SQ_WIDTH'(hl_ff) << (psd_pkg::HALF_WIDTH + 1))
                + psd_pkg::SQ_WIDTH'(ll_ff);

   // Divide stages: one quotient bit per stage, then subtract from the candidate for interior results
   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0].rem    <= sq_in[psd_pkg::SQ_WIDTH-1:psd_pkg::DIST_WIDTH];
         div_ff[0].dvd    <= sq_in[psd_pkg::DIST_WIDTH-1:0];
         div_ff[0].quo    <= '0;
         div_ff[0].div    <= f4_ff;
         div_ff[0].cand   <= cand4_ff;
         div_ff[0].region <= region4_ff;
         for (int k = 1; k <= psd_pkg::DIV_STEPS; k++) begin
            div_ff[k] <= div_step(div_ff[k-1]);
         end
         dist_ff   <= (div_ff[psd_pkg::DIV_STEPS].region == psd_pkg::REGION_INTERIOR)
                    ? div_ff[psd_pkg::DIV_STEPS].cand - div_ff[psd_pkg::DIV_STEPS].quo
                    : div_ff[psd_pkg::DIV_STEPS].cand;
         region_ff <= div_ff[psd_pkg::DIV_STEPS].region;
      end
   end

   assign rsp_chan.valid          = vld_ff[psd_pkg::NUM_STAGES-1];
   assign rsp_chan.sq_distance    = dist_ff;
   assign rsp_chan.nearest_region = region_ff;

`include "point_segment_sq_distance_top_assert.svh"

   // The interior quotient never exceeds the squared distance to the start
   `PSD_ASSERT_NOW(a_quo_bound, vld_ff[psd_pkg::NUM_STAGES-2] && (div_ff[psd_pkg::DIV_STEPS].region == psd_pkg::REGION_INTERIOR), div_ff[psd_pkg::DIV_STEPS].quo <= div_ff[psd_pkg::DIV_STEPS].cand)
   // A stalled response keeps its output stage intact
   `PSD_ASSERT_NEXT(a_out_hold, vld_ff[psd_pkg::NUM_STAGES-1] && !rsp_chan.ready, vld_ff[psd_pkg::NUM_STAGES-1] && $stable(dist_ff) && $stable(region_ff))
   // Requests are refused only while a response waits
   `PSD_ASSERT_NOW(a_ready_stall, req_chan.valid && !req_chan.ready, rsp_chan.valid && !rsp_chan.ready)

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the point-to-segment squared distance block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 850;
   localparam int CALM_FROM      = 760;   // no idling from this request on
   localparam int HOLD_AT        = 250;   // receiver long hold-off starts here
   localparam int HOLD_CYCLES    = 160;
   localparam int DRAIN_AT       = 500;   // sender waits for an empty pipe here
   localparam int SETTLE_CYCLES  = 60;
   localparam int STALL_LIMIT    = 3000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      psd_pkg::coord_type point_x, point_y, point_z;
      psd_pkg::coord_type start_x, start_y, start_z;
      psd_pkg::coord_type end_x, end_y, end_z;
   } segment_query_type;

   typedef struct packed {
      psd_pkg::dist_type   sq_distance;
      psd_pkg::region_type nearest_region;
   } distance_result_type;

   typedef struct {
      segment_query_type   query;
      bit                  typed;
      distance_result_type result;
   } directed_row_type;

   logic clock;
   logic reset;

   psd_req_if req_chan ();
   psd_rsp_if rsp_chan ();

   point_segment_sq_distance_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   distance_result_type pending_results[$];
   int  mismatch_count = 0;
   int  requests_sent  = 0;
   int  results_seen   = 0;
   int  interior_seen  = 0;
   int  end_seen       = 0;
   int  start_seen     = 0;
   bit  calm_phase     = 0;
   bit  stimulus_done  = 0;

   // Generate clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Compute the squared distance, with the interior quotient truncated, and the region of the nearest point
   function automatic distance_result_type predict_distance(segment_query_type q);
      longint ab[3], ac[3], bc[3];
      longint along, seg_len, ac_len;
      logic [127:0] num, den;
      distance_result_type r;
      ab[0] = longint'(q.end_x) - longint'(q.start_x);
      ab[1] = longint'(q.end_y) - longint'(q.start_y);
      ab[2] = longint'(q.end_z) - longint'(q.start_z);
      ac[0] = longint'(q.point_x) - longint'(q.start_x);
      ac[1] = longint'(q.point_y) - longint'(q.start_y);
      ac[2] = longint'(q.point_z) - longint'(q.start_z);
      bc[0] = longint'(q.point_x) - longint'(q.end_x);
      bc[1] = longint'(q.point_y) - longint'(q.end_y);
      bc[2] = longint'(q.point_z) - longint'(q.end_z);
      along  = ac[0] * ab[0] + ac[1] * ab[1] + ac[2] * ab[2];
      ac_len = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
      seg_len = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
      if (along <= 0) begin
         r.sq_distance    = psd_pkg::dist_type'(ac_len);
         r.nearest_region = psd_pkg::REGION_START;
      end else if (along >= seg_len) begin
         r.sq_distance    = psd_pkg::dist_type'(bc[0] * bc[0] + bc[1] * bc[1]
                                                + bc[2] * bc[2]);
         r.nearest_region = psd_pkg::REGION_END;
      end else begin
         num = 128'(along);
         num = num * num;
         den = 128'(seg_len);
         r.sq_distance    = psd_pkg::dist_type'(128'(ac_len) - num / den);
         r.nearest_region = psd_pkg::REGION_INTERIOR;
      end
      return r;
   endfunction

   function automatic segment_query_type make_query(int px, int py, int pz, int sx, int sy,
                                                    int sz, int ex, int ey, int ez);
      segment_query_type q;
      q.point_x = psd_pkg::coord_type'(px);
      q.point_y = psd_pkg::coord_type'(py);
      q.point_z = psd_pkg::coord_type'(pz);
      q.start_x = psd_pkg::coord_type'(sx);
      q.start_y = psd_pkg::coord_type'(sy);
      q.start_z = psd_pkg::coord_type'(sz);
      q.end_x   = psd_pkg::coord_type'(ex);
      q.end_y   = psd_pkg::coord_type'(ey);
      q.end_z   = psd_pkg::coord_type'(ez);
      return q;
   endfunction

   function automatic psd_pkg::coord_type pick_coord(int mode);
      if (mode == 0)
         return psd_pkg::coord_type'($urandom);
      return psd_pkg::coord_type'($urandom_range(0, 128) - 64);
   endfunction

   // Random query: full range or near-origin, with some degenerate and on-axis cases
   function automatic segment_query_type random_query();
      segment_query_type q;
      int mode, kind, t;
      mode = $urandom_range(0, 1);
      kind = $urandom_range(0, 9);
      q.point_x = pick_coord(mode); q.point_y = pick_coord(mode); q.point_z = pick_coord(mode);
      q.start_x = pick_coord(mode); q.start_y = pick_coord(mode); q.start_z = pick_coord(mode);
      q.end_x   = pick_coord(mode); q.end_y   = pick_coord(mode); q.end_z   = pick_coord(mode);
      if (kind == 0) begin
         // collapse the segment to a single point
         q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
      end else if (kind == 1) begin
         // put the point at a random fraction along the segment, off by a little
         t = $urandom_range(0, 8);
         q.start_x = psd_pkg::coord_type'($urandom_range(0, 4000) - 2000);
         q.start_y = psd_pkg::coord_type'($urandom_range(0, 4000) - 2000);
         q.start_z = psd_pkg::coord_type'($urandom_range(0, 4000) - 2000);
         q.point_x = q.start_x
                   + psd_pkg::coord_type'(($signed(q.end_x) - $signed(q.start_x)) * t / 8);
         q.point_y = q.start_y + psd_pkg::coord_type'($urandom_range(0, 6) - 3);
         q.point_z = q.start_z;
         q.end_y   = q.start_y;
         q.end_z   = q.start_z;
      end
      return q;
   endfunction

   // Offer one request and hold it until it is taken
   task automatic send_request(segment_query_type q, bit typed,
                               distance_result_type typed_result);
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.point_x <= q.point_x; req_chan.point_y <= q.point_y;
      req_chan.point_z <= q.point_z;
      req_chan.start_x <= q.start_x; req_chan.start_y <= q.start_y;
      req_chan.start_z <= q.start_z;
      req_chan.end_x   <= q.end_x;   req_chan.end_y   <= q.end_y;
      req_chan.end_z   <= q.end_z;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(typed ? typed_result : predict_distance(q));
      requests_sent++;
   endtask

   task automatic idle_request_side();
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9) - 1) @(negedge clock);
      end
   endtask

   // Stimulus: directed table, then random requests
   initial begin
      directed_row_type rows[$];
      distance_result_type none;
      none = '0;
      req_chan.valid = 1'b0;
      req_chan.point_x = '0; req_chan.point_y = '0; req_chan.point_z = '0;
      req_chan.start_x = '0; req_chan.start_y = '0; req_chan.start_z = '0;
      req_chan.end_x   = '0; req_chan.end_y   = '0; req_chan.end_z   = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows.push_back('{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       '{34'd0, psd_pkg::REGION_START}});
      // degenerate segment
      rows.push_back('{make_query(1, 2, 3, 0, 0, 0, 0, 0, 0), 1,
                       '{34'd14, psd_pkg::REGION_START}});
      // projection exactly at the start
      rows.push_back('{make_query(0, 7, 0, 0, 0, 0, 10, 0, 0), 1,
                       '{34'd49, psd_pkg::REGION_START}});
      // projection exactly at the end
      rows.push_back('{make_query(10, 5, 0, 0, 0, 0, 10, 0, 0), 1,
                       '{34'd25, psd_pkg::REGION_END}});
      rows.push_back('{make_query(20, 0, 0, 0, 0, 0, 10, 0, 0), 1,
                       '{34'd100, psd_pkg::REGION_END}});
      rows.push_back('{make_query(5, 3, 0, 0, 0, 0, 10, 0, 0), 1,
                       '{34'd9, psd_pkg::REGION_INTERIOR}});
      // largest distance, both signs
      rows.push_back('{make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                                  32767, 32767, 32767), 1,
                       '{34'd12884508675, psd_pkg::REGION_START}});
      rows.push_back('{make_query(32767, 32767, 32767, -32768, -32768, -32768,
                                  -32768, -32768, -32768), 1,
                       '{34'd12884508675, psd_pkg::REGION_START}});
      rows.push_back('{make_query(0, 0, 0, -32768, -32768, -32768,
                                  32767, 32767, 32767), 0, none});
      rows.push_back('{make_query(32767, -32768, 32767, -32768, 32767, -32768,
                                  32767, 32767, -32768), 0, none});
      rows.push_back('{make_query(-32768, 32767, 0, -32768, -32768, -32768,
                                  32767, 32767, 32767), 0, none});
      rows.push_back('{make_query(1, 1, 1, -32768, 0, 0, 32767, 0, 0), 0, none});
      rows.push_back('{make_query(32767, 32767, 32767, -32768, -32768, -32768,
                                  32767, 32767, 32766), 0, none});
      rows.push_back('{make_query(-1, -1, -1, 0, 0, 0, 3, 1, 2), 0, none});

      foreach (rows[i]) begin
         idle_request_side();
         send_request(rows[i].query, rows[i].typed, rows[i].result);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == CALM_FROM)
            calm_phase = 1;
         if (n == DRAIN_AT) begin
            // pause until the pipe is empty
            @(negedge clock);
            req_chan.valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         idle_request_side();
         send_request(random_query(), 0, none);
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
      stimulus_done = 1;
   end

   // Drive response ready: random stalls, one long hold-off, none at the end
   initial begin
      bit held;
      held = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && requests_sent >= HOLD_AT) begin
            held = 1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: response with nothing pending: dist=%0d region=%0d",
                        rsp_chan.sq_distance, rsp_chan.nearest_region);
         end else begin
            want = pending_results.pop_front();
            case (want.nearest_region)
               psd_pkg::REGION_START: start_seen++;
               psd_pkg::REGION_END:   end_seen++;
               default:               interior_seen++;
            endcase
            if (rsp_chan.sq_distance !== want.sq_distance ||
                rsp_chan.nearest_region !== want.nearest_region) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ERROR: response %0d expected dist=%0d region=%0d, %s%0d region=%0d",
                           results_seen, want.sq_distance, want.nearest_region,
                           "got dist=", rsp_chan.sq_distance, rsp_chan.nearest_region);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles, %0d results pending",
                     quiet, pending_results.size());
            $display("point_segment_sq_distance_top verification failed");
            $finish;
         end
      end
   end

   // Drain, settle, report
   initial begin
      wait (stimulus_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         mismatch_count++;
      $display("Ran %0d requests, checked %0d responses: %0d start, %0d end, %0d interior.",
               requests_sent, results_seen, start_seen, end_seen, interior_seen);
      $display("Included a long response hold-off, a full drain pause and %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0)
         $display("point_segment_sq_distance_top verification clean");
      else
         $display("point_segment_sq_distance_top verification failed");
      $finish;
   end

endmodule
